### src/tpa_pkg.sv
// Shared constants, types and the offer schedule for the two-piece affine aligner.
// Used by tpa_offer and the top level; depends on nothing.
package tpa_pkg;

  localparam int MAX_LEN    = 64;
  localparam int NSTATES    = 5;
  localparam int COLS       = MAX_LEN + 1;
  localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int COL_AW     = $clog2(COLS);
  localparam int PTR_DEPTH  = COLS * COLS;
  localparam int PTR_AW     = $clog2(PTR_DEPTH);
  localparam int PATH_DEPTH = 2 * MAX_LEN;
  localparam int PATH_AW    = $clog2(PATH_DEPTH);
  localparam int PLEN_W     = $clog2(PATH_DEPTH + 1);
  localparam int SCORE_W    = 32;
  localparam int CFG_W      = 16;
  localparam int DELTA_W    = CFG_W + 1;
  localparam int NUM_CFG    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_OFFERS = 21;
  localparam int OFFER_W    = 5;
  localparam int PRED_W     = 3;
  localparam int SYM_W      = 8;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef score_t [NSTATES-1:0] row_t;
  typedef logic [PRED_W-1:0] pred_t;
  typedef pred_t [NSTATES-1:0] ptr_t;

  localparam score_t NEG_INF = 32'shC000_0000;
  localparam logic [SYM_W-1:0] GAP_CHAR = 8'h2D;

  // alignment states, also used as predecessor codes
  localparam pred_t ST_MATCH = 3'd0;
  localparam pred_t ST_GS1   = 3'd1;
  localparam pred_t ST_GS2   = 3'd2;
  localparam pred_t ST_GF1   = 3'd3;
  localparam pred_t ST_GF2   = 3'd4;
  localparam pred_t NO_PRED  = 3'd7;

  localparam logic [2:0] CMD_APPEND_FIRST  = 3'd0;
  localparam logic [2:0] CMD_APPEND_SECOND = 3'd1;
  localparam logic [2:0] CMD_ALIGN         = 3'd2;
  localparam logic [2:0] CMD_NEXT          = 3'd3;
  localparam logic [2:0] CMD_CLEAR         = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] MV_DIAG = 2'd0;
  localparam logic [1:0] MV_UP   = 2'd1;
  localparam logic [1:0] MV_LEFT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXT2     = 3'd5;

  localparam logic signed [CFG_W-1:0] RST_MATCH    = 16'sd2;
  localparam logic signed [CFG_W-1:0] RST_MISMATCH = -16'sd4;
  localparam logic signed [CFG_W-1:0] RST_OPEN1    = -16'sd4;
  localparam logic signed [CFG_W-1:0] RST_EXT1     = -16'sd2;
  localparam logic signed [CFG_W-1:0] RST_OPEN2    = -16'sd24;
  localparam logic signed [CFG_W-1:0] RST_EXT2     = -16'sd1;

  typedef enum logic [1:0] {SRC_DIAG, SRC_UP, SRC_LEFT} src_t;
  typedef enum logic [2:0] {D_SUB, D_EXT1, D_EXT2, D_OPEN1, D_OPEN2} dsel_t;

  typedef struct packed {
    pred_t tgt;
    src_t  src;
    pred_t from;
    dsel_t dsel;
  } offer_t;

  // Offer order per cell; within one target state the order sets tie behavior.
  function automatic offer_t offer_entry(input logic [OFFER_W-1:0] k);
    offer_t e;
    case (k)
      5'd0:    e = '{ST_MATCH, SRC_DIAG, ST_MATCH, D_SUB};
      5'd1:    e = '{ST_MATCH, SRC_DIAG, ST_GS1,   D_SUB};
      5'd2:    e = '{ST_MATCH, SRC_DIAG, ST_GS2,   D_SUB};
      5'd3:    e = '{ST_MATCH, SRC_DIAG, ST_GF1,   D_SUB};
      5'd4:    e = '{ST_MATCH, SRC_DIAG, ST_GF2,   D_SUB};
      5'd5:    e = '{ST_GS1,   SRC_UP,   ST_GS1,   D_EXT1};
      5'd6:    e = '{ST_GS2,   SRC_UP,   ST_GS2,   D_EXT2};
      5'd7:    e = '{ST_GS1,   SRC_UP,   ST_MATCH, D_OPEN1};
      5'd8:    e = '{ST_GS2,   SRC_UP,   ST_MATCH, D_OPEN2};
      5'd9:    e = '{ST_GS1,   SRC_UP,   ST_GF1,   D_OPEN1};
      5'd10:   e = '{ST_GS2,   SRC_UP,   ST_GF1,   D_OPEN2};
      5'd11:   e = '{ST_GS1,   SRC_UP,   ST_GF2,   D_OPEN1};
      5'd12:   e = '{ST_GS2,   SRC_UP,   ST_GF2,   D_OPEN2};
      5'd13:   e = '{ST_GF1,   SRC_LEFT, ST_GF1,   D_EXT1};
      5'd14:   e = '{ST_GF2,   SRC_LEFT, ST_GF2,   D_EXT2};
      5'd15:   e = '{ST_GF1,   SRC_LEFT, ST_MATCH, D_OPEN1};
      5'd16:   e = '{ST_GF2,   SRC_LEFT, ST_MATCH, D_OPEN2};
      5'd17:   e = '{ST_GF1,   SRC_LEFT, ST_GS1,   D_OPEN1};
      5'd18:   e = '{ST_GF2,   SRC_LEFT, ST_GS1,   D_OPEN2};
      5'd19:   e = '{ST_GF1,   SRC_LEFT, ST_GS2,   D_OPEN1};
      5'd20:   e = '{ST_GF2,   SRC_LEFT, ST_GS2,   D_OPEN2};
      default: e = '{ST_MATCH, SRC_DIAG, ST_MATCH, D_SUB};
    endcase
    return e;
  endfunction

endpackage

### src/tpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tpa_offer.sv
// Shared add-clamp-compare unit: one candidate offer per cycle.
// Depends on tpa_pkg.
module tpa_offer (
  input  tpa_pkg::score_t                    base,
  input  logic signed [tpa_pkg::DELTA_W-1:0] delta,
  input  tpa_pkg::score_t                    current,
  output tpa_pkg::score_t                    cand,
  output logic                               take
);

  logic signed [tpa_pkg::SCORE_W:0] sum;

  always_comb begin
    sum = (tpa_pkg::SCORE_W + 1)'(base) + (tpa_pkg::SCORE_W + 1)'(delta);
    // minus infinity is sticky, and anything below it clamps to it
    if (base <= tpa_pkg::NEG_INF || sum < (tpa_pkg::SCORE_W + 1)'(tpa_pkg::NEG_INF)) begin
      cand = tpa_pkg::NEG_INF;
    end else begin
      cand = sum[tpa_pkg::SCORE_W-1:0];
    end
    take = cand > current;
  end

endmodule

### src/two_piece_affine_global_aligner_top.sv
// Top level: command decode, alignment sequencer, traceback and column readout.
// Depends on tpa_pkg, tpa_ram and tpa_offer.
//
// Commands are taken when start is high and busy is low; each yields one result,
// shown for one cycle with done high, which the receiver cannot hold off. Appends,
// clear, unknown commands and an empty next-column request raise done in the cycle
// after acceptance; a next-column read passes a read state and an output state.
// Align passes a setup state, then walks (n+1)*(m+1) cells through a single
// add-clamp-compare unit that evaluates 21 offers per cell; each cell takes a row
// read, a load, the offers and a write-back, and the origin cell skips the offers.
// Then the end states are compared to pick the best, a setup state starts the
// traceback, and the traceback reads the pointer memory port once per path column
// until it stops. All memories start undefined and need no clearing pass.
module two_piece_affine_global_aligner_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        command,
  input  logic [tpa_pkg::SYM_W-1:0]         symbol,
  input  logic                              cfg_write,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpa_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [tpa_pkg::SCORE_W-1:0] score,
  output logic [tpa_pkg::SYM_W-1:0]         first_symbol,
  output logic [tpa_pkg::SYM_W-1:0]         second_symbol,
  output logic                              first_is_gap,
  output logic                              second_is_gap,
  output logic                              last
);

  typedef enum logic [3:0] {
    S_IDLE, S_AL_INIT, S_RD, S_LOAD, S_OFFER, S_WRITE, S_FIN, S_TB_INIT,
    S_TB_RD, S_TB_STEP, S_COL_RD, S_COL_OUT
  } state_t;

  state_t state;

  logic signed [tpa_pkg::CFG_W-1:0]   cfg_r [tpa_pkg::NUM_CFG];
  logic signed [tpa_pkg::DELTA_W-1:0] open1, open2;

  logic [tpa_pkg::LEN_W-1:0]   first_length, second_length;
  logic [tpa_pkg::LEN_W-1:0]   row_i, col_j;
  logic [tpa_pkg::PTR_AW-1:0]  ptr_addr, row_base;
  logic [tpa_pkg::OFFER_W-1:0] k;
  logic [tpa_pkg::PLEN_W-1:0]  path_length, read_position;
  logic [tpa_pkg::LEN_W-1:0]   first_cursor, second_cursor;
  logic                        aligned_flag;
  tpa_pkg::score_t             best_score;
  tpa_pkg::pred_t              best, bidx, st_tb;

  tpa_pkg::row_t sc, up, diag, left;
  tpa_pkg::ptr_t pr;
  logic          sym_eq;

  // memory ports
  logic [tpa_pkg::SYM_W-1:0]              f_rd, s_rd;
  logic [tpa_pkg::IDX_W-1:0]              f_raddr, s_raddr;
  logic                                   f_we, s_we;
  tpa_pkg::row_t                          row_rd;
  tpa_pkg::ptr_t                          ptr_rd;
  logic [1:0]                             path_rd;
  logic [tpa_pkg::PATH_AW-1:0]            path_raddr;
  logic [tpa_pkg::COL_AW-1:0]             row_addr;

  logic accept;
  assign accept = start && !busy;
  assign busy   = state != S_IDLE;
  assign score  = best_score;

  // offer path
  tpa_pkg::offer_t                    ent;
  tpa_pkg::score_t                    base, current, cand;
  logic signed [tpa_pkg::DELTA_W-1:0] delta;
  logic                               offer_ok, take;

  always_comb begin
    ent = tpa_pkg::offer_entry(k);
    case (ent.src)
      tpa_pkg::SRC_DIAG: begin
        base     = diag[ent.from];
        offer_ok = row_i != '0 && col_j != '0;
      end
      tpa_pkg::SRC_UP: begin
        base     = up[ent.from];
        offer_ok = row_i != '0;
      end
      default: begin
        base     = left[ent.from];
        offer_ok = col_j != '0;
      end
    endcase
    case (ent.dsel)
      tpa_pkg::D_SUB:   delta = sym_eq ? tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_MATCH])
                                       : tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_MISMATCH]);
      tpa_pkg::D_EXT1:  delta = tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_EXT1]);
      tpa_pkg::D_EXT2:  delta = tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_EXT2]);
      tpa_pkg::D_OPEN1: delta = open1;
      default:          delta = open2;
    endcase
    current = sc[ent.tgt];
  end

  tpa_offer u_offer (
    .base    (base),
    .delta   (delta),
    .current (current),
    .cand    (cand),
    .take    (take)
  );

  // traceback step
  tpa_pkg::pred_t tb_pred;
  logic           tb_ok, tb_cont;
  logic [1:0]     tb_mv;

  always_comb begin
    tb_pred = ptr_rd[st_tb];
    tb_cont = (row_i != '0 || col_j != '0) &&
              path_length < tpa_pkg::PLEN_W'(tpa_pkg::PATH_DEPTH);
    case (st_tb)
      tpa_pkg::ST_MATCH: begin
        tb_ok = row_i != '0 && col_j != '0;
        tb_mv = tpa_pkg::MV_DIAG;
      end
      tpa_pkg::ST_GS1, tpa_pkg::ST_GS2: begin
        tb_ok = row_i != '0;
        tb_mv = tpa_pkg::MV_UP;
      end
      tpa_pkg::ST_GF1, tpa_pkg::ST_GF2: begin
        tb_ok = col_j != '0;
        tb_mv = tpa_pkg::MV_LEFT;
      end
      default: begin
        tb_ok = 1'b0;
        tb_mv = tpa_pkg::MV_DIAG;
      end
    endcase
  end

  // result strobe for the transaction that ends in this cycle
  logic next_ok, finish;
  assign next_ok = aligned_flag && read_position < path_length;
  assign finish  = (state == S_IDLE && accept && command != tpa_pkg::CMD_ALIGN &&
                    !(command == tpa_pkg::CMD_NEXT && next_ok)) ||
                   (state == S_TB_RD && !tb_cont) ||
                   (state == S_TB_STEP && !tb_ok) ||
                   state == S_COL_OUT;

  // read address selection
  logic [tpa_pkg::LEN_W-1:0]  i_m1, j_m1;
  logic [tpa_pkg::PLEN_W-1:0] path_idx;

  always_comb begin
    i_m1     = row_i - tpa_pkg::LEN_W'(1);
    j_m1     = col_j - tpa_pkg::LEN_W'(1);
    path_idx = path_length - tpa_pkg::PLEN_W'(1) - read_position;
    if (state == S_COL_RD) begin
      f_raddr = first_cursor[tpa_pkg::IDX_W-1:0];
      s_raddr = second_cursor[tpa_pkg::IDX_W-1:0];
    end else begin
      f_raddr = i_m1[tpa_pkg::IDX_W-1:0];
      s_raddr = j_m1[tpa_pkg::IDX_W-1:0];
    end
    path_raddr = path_idx[tpa_pkg::PATH_AW-1:0];
    row_addr   = col_j[tpa_pkg::COL_AW-1:0];
    f_we = accept && command == tpa_pkg::CMD_APPEND_FIRST &&
           first_length < tpa_pkg::LEN_W'(tpa_pkg::MAX_LEN);
    s_we = accept && command == tpa_pkg::CMD_APPEND_SECOND &&
           second_length < tpa_pkg::LEN_W'(tpa_pkg::MAX_LEN);
  end

  tpa_ram #(.WIDTH(tpa_pkg::SYM_W), .DEPTH(tpa_pkg::MAX_LEN)) u_first_store (
    .clk (clk), .we (f_we), .waddr (first_length[tpa_pkg::IDX_W-1:0]),
    .wdata (symbol), .raddr (f_raddr), .rdata (f_rd)
  );

  tpa_ram #(.WIDTH(tpa_pkg::SYM_W), .DEPTH(tpa_pkg::MAX_LEN)) u_second_store (
    .clk (clk), .we (s_we), .waddr (second_length[tpa_pkg::IDX_W-1:0]),
    .wdata (symbol), .raddr (s_raddr), .rdata (s_rd)
  );

  // one DP row, updated in place: entry j is read as "up" before it is rewritten
  tpa_ram #(.WIDTH(tpa_pkg::NSTATES * tpa_pkg::SCORE_W), .DEPTH(tpa_pkg::COLS)) u_rows (
    .clk (clk), .we (state == S_WRITE), .waddr (row_addr),
    .wdata (sc), .raddr (row_addr), .rdata (row_rd)
  );

  tpa_ram #(.WIDTH(tpa_pkg::NSTATES * tpa_pkg::PRED_W), .DEPTH(tpa_pkg::PTR_DEPTH)) u_ptr (
    .clk (clk), .we (state == S_WRITE), .waddr (ptr_addr),
    .wdata (pr), .raddr (ptr_addr), .rdata (ptr_rd)
  );

  tpa_ram #(.WIDTH(2), .DEPTH(tpa_pkg::PATH_DEPTH)) u_path (
    .clk (clk), .we (state == S_TB_STEP && tb_ok),
    .waddr (path_length[tpa_pkg::PATH_AW-1:0]), .wdata (tb_mv),
    .raddr (path_raddr), .rdata (path_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cfg_r[tpa_pkg::REG_MATCH]    <= tpa_pkg::RST_MATCH;
      cfg_r[tpa_pkg::REG_MISMATCH] <= tpa_pkg::RST_MISMATCH;
      cfg_r[tpa_pkg::REG_OPEN1]    <= tpa_pkg::RST_OPEN1;
      cfg_r[tpa_pkg::REG_EXT1]     <= tpa_pkg::RST_EXT1;
      cfg_r[tpa_pkg::REG_OPEN2]    <= tpa_pkg::RST_OPEN2;
      cfg_r[tpa_pkg::REG_EXT2]     <= tpa_pkg::RST_EXT2;
      first_length  <= '0;
      second_length <= '0;
      path_length   <= '0;
      read_position <= '0;
      first_cursor  <= '0;
      second_cursor <= '0;
      aligned_flag  <= 1'b0;
      best_score    <= '0;
      done          <= 1'b0;
      status        <= tpa_pkg::STAT_OK;
      first_symbol  <= '0;
      second_symbol <= '0;
      first_is_gap  <= 1'b0;
      second_is_gap <= 1'b0;
      last          <= 1'b0;
    end else begin
      done <= finish;
      if (cfg_write && cfg_index < tpa_pkg::CFG_IDX_W'(tpa_pkg::NUM_CFG)) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            first_symbol  <= '0;
            second_symbol <= '0;
            first_is_gap  <= 1'b0;
            second_is_gap <= 1'b0;
            last          <= 1'b0;
            if ((command == tpa_pkg::CMD_APPEND_FIRST && !f_we) ||
                (command == tpa_pkg::CMD_APPEND_SECOND && !s_we)) begin
              status <= tpa_pkg::STAT_FULL;
            end else if (command == tpa_pkg::CMD_NEXT && !next_ok) begin
              status <= tpa_pkg::STAT_EMPTY;
            end else begin
              status <= tpa_pkg::STAT_OK;
            end
            case (command)
              tpa_pkg::CMD_APPEND_FIRST, tpa_pkg::CMD_APPEND_SECOND: begin
                if (f_we || s_we) begin
                  if (f_we) first_length <= first_length + tpa_pkg::LEN_W'(1);
                  if (s_we) second_length <= second_length + tpa_pkg::LEN_W'(1);
                  aligned_flag  <= 1'b0;
                  path_length   <= '0;
                  read_position <= '0;
                  first_cursor  <= '0;
                  second_cursor <= '0;
                end
              end
              tpa_pkg::CMD_ALIGN: begin
                state <= S_AL_INIT;
              end
              tpa_pkg::CMD_NEXT: begin
                if (next_ok) begin
                  state <= S_COL_RD;
                end
              end
              tpa_pkg::CMD_CLEAR: begin
                first_length  <= '0;
                second_length <= '0;
                best_score    <= '0;
                aligned_flag  <= 1'b0;
                path_length   <= '0;
                read_position <= '0;
                first_cursor  <= '0;
                second_cursor <= '0;
              end
              default: ;
            endcase
          end
        end
        S_AL_INIT: begin
          open1    <= tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_OPEN1]) +
                      tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_EXT1]);
          open2    <= tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_OPEN2]) +
                      tpa_pkg::DELTA_W'(cfg_r[tpa_pkg::REG_EXT2]);
          row_i    <= '0;
          col_j    <= '0;
          row_base <= '0;
          ptr_addr <= '0;
          state    <= S_RD;
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          up     <= row_rd;
          sym_eq <= f_rd == s_rd;
          k      <= '0;
          // the origin cell starts the match state at zero
          for (int s = 0; s < tpa_pkg::NSTATES; s++) begin
            sc[s] <= (s == int'(tpa_pkg::ST_MATCH) && row_i == '0 && col_j == '0) ?
                     '0 : tpa_pkg::NEG_INF;
            pr[s] <= tpa_pkg::NO_PRED;
          end
          if (row_i == '0 && col_j == '0) begin
            state <= S_WRITE;
          end else begin
            state <= S_OFFER;
          end
        end
        S_OFFER: begin
          if (offer_ok && take) begin
            sc[ent.tgt] <= cand;
            pr[ent.tgt] <= ent.from;
          end
          k <= k + tpa_pkg::OFFER_W'(1);
          if (k == tpa_pkg::OFFER_W'(tpa_pkg::NUM_OFFERS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          diag <= up;
          left <= sc;
          if (col_j == second_length) begin
            if (row_i == first_length) begin
              best  <= tpa_pkg::ST_MATCH;
              bidx  <= tpa_pkg::ST_GS1;
              state <= S_FIN;
            end else begin
              row_i    <= row_i + tpa_pkg::LEN_W'(1);
              col_j    <= '0;
              row_base <= row_base + tpa_pkg::PTR_AW'(tpa_pkg::COLS);
              ptr_addr <= row_base + tpa_pkg::PTR_AW'(tpa_pkg::COLS);
              state    <= S_RD;
            end
          end else begin
            col_j    <= col_j + tpa_pkg::LEN_W'(1);
            ptr_addr <= ptr_addr + tpa_pkg::PTR_AW'(1);
            state    <= S_RD;
          end
        end
        S_FIN: begin
          // first strictly greater end state wins
          if ($signed(left[bidx]) > $signed(left[best])) begin
            best <= bidx;
          end
          bidx <= bidx + tpa_pkg::PRED_W'(1);
          if (bidx == tpa_pkg::ST_GF2) begin
            state <= S_TB_INIT;
          end
        end
        S_TB_INIT: begin
          // ptr_addr still points at the last cell (n, m)
          best_score    <= left[best];
          st_tb         <= best;
          aligned_flag  <= 1'b0;
          path_length   <= '0;
          read_position <= '0;
          first_cursor  <= '0;
          second_cursor <= '0;
          state         <= S_TB_RD;
        end
        S_TB_RD: begin
          if (tb_cont) begin
            state <= S_TB_STEP;
          end else begin
            aligned_flag <= 1'b1;
            status       <= tpa_pkg::STAT_OK;
            state        <= S_IDLE;
          end
        end
        S_TB_STEP: begin
          if (tb_ok) begin
            case (tb_mv)
              tpa_pkg::MV_DIAG: begin
                row_i    <= row_i - tpa_pkg::LEN_W'(1);
                col_j    <= col_j - tpa_pkg::LEN_W'(1);
                ptr_addr <= ptr_addr - tpa_pkg::PTR_AW'(tpa_pkg::COLS + 1);
              end
              tpa_pkg::MV_UP: begin
                row_i    <= row_i - tpa_pkg::LEN_W'(1);
                ptr_addr <= ptr_addr - tpa_pkg::PTR_AW'(tpa_pkg::COLS);
              end
              default: begin
                col_j    <= col_j - tpa_pkg::LEN_W'(1);
                ptr_addr <= ptr_addr - tpa_pkg::PTR_AW'(1);
              end
            endcase
            path_length <= path_length + tpa_pkg::PLEN_W'(1);
            st_tb       <= tb_pred;
            state       <= S_TB_RD;
          end else begin
            aligned_flag <= 1'b1;
            status       <= tpa_pkg::STAT_OK;
            state        <= S_IDLE;
          end
        end
        S_COL_RD: begin
          state <= S_COL_OUT;
        end
        S_COL_OUT: begin
          if (path_rd == tpa_pkg::MV_LEFT) begin
            first_symbol <= tpa_pkg::GAP_CHAR;
            first_is_gap <= 1'b1;
          end else begin
            first_symbol <= f_rd;
            first_is_gap <= 1'b0;
            first_cursor <= first_cursor + tpa_pkg::LEN_W'(1);
          end
          if (path_rd == tpa_pkg::MV_UP) begin
            second_symbol <= tpa_pkg::GAP_CHAR;
            second_is_gap <= 1'b1;
          end else begin
            second_symbol <= s_rd;
            second_is_gap <= 1'b0;
            second_cursor <= second_cursor + tpa_pkg::LEN_W'(1);
          end
          read_position <= read_position + tpa_pkg::PLEN_W'(1);
          last   <= (read_position + tpa_pkg::PLEN_W'(1)) == path_length;
          status <= tpa_pkg::STAT_OK;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is still in progress");
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
      done && last |-> status == tpa_pkg::STAT_OK)
    else $error("last column flagged on a failed transaction");
  a_one_gap: assert property (@(posedge clk) disable iff (rst)
      done |-> !(first_is_gap && second_is_gap))
    else $error("column with gaps in both sequences");
  a_path_bound: assert property (@(posedge clk) disable iff (rst)
      path_length <= tpa_pkg::PLEN_W'(tpa_pkg::PATH_DEPTH) && read_position <= path_length)
    else $error("path bookkeeping out of range");

endmodule
